### rtl/bitmap_block_allocator_unit_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### rtl/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

  localparam int DATA_W         = 32;
  localparam int BS_W           = 16;
  localparam int WC_W           = 7;
  localparam int WC_MAX         = (1 << WC_W) - 1;
  localparam int BIT_W          = 5;
  localparam int WORD_BITS      = 1 << BIT_W;
  localparam int IX_W           = WC_W + BIT_W;
  localparam int OFF_W          = IX_W + BS_W;
  localparam int CNT_W          = 12;
  localparam int OUT_IX_W       = 11;
  localparam int STATUS_W       = 3;
  localparam int CFG_AW         = 4;
  localparam int DIV_CW         = $clog2(IX_W);
  localparam int MAP_WORDS_DEF  = 64;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam logic [DATA_W-1:0] BASE_RST = '0;
  localparam logic [BS_W-1:0]   BS_RST   = 16'd32;
  localparam logic [WC_W-1:0]   WC_RST   = 7'd64;

  localparam logic FUNC_ALLOC = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NONE_FREE = 3'd1,
    ST_RANGE     = 3'd2,
    ST_UNALIGNED = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_ARENA_BASE = 2'd0,
    REG_BLOCK_SIZE = 2'd1,
    REG_WORD_COUNT = 2'd2
  } cfg_reg_t;

endpackage

### rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bitmap_block_allocator_unit.sv
// Top level of the bitmap block allocator: control, arithmetic and config port.
//
// Fixed-size block allocator over a free bitmap held in one RAM (1 = free).
// After reset the bitmap RAM is set to all ones by a clearing pass, during
// which no request is taken; configuration writes are taken at any time the
// block is idle. One request is in work at a time. An allocate streams the
// bitmap words in use through the RAM read port, one word per cycle; the
// scan rate is set by the single read port. A free runs through a 12-step
// radix-2 divider that works out the block index and alignment. A finished
// result waits in an output register, and the next request is taken while
// it waits.
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MAP_WORDS  = MAP_WORDS_DEF,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [DATA_W-1:0]   in_free_addr,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_block_addr,
  output logic [OUT_IX_W-1:0] out_block_index,
  output logic [CNT_W-1:0]    out_used_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  `include "bitmap_block_allocator_unit_macros.svh"

  localparam int MW_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int NW_CAP = (MAP_WORDS < WC_MAX) ? MAP_WORDS : WC_MAX;
  localparam int KEEP   = (ADDR_WIDTH < DATA_W) ? ADDR_WIDTH : DATA_W;
  localparam logic [DATA_W-1:0] AMASK = {DATA_W{1'b1}} >> (DATA_W - KEEP);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_MUL, S_ADD, S_SPAN, S_CHK, S_DIV, S_IDX, S_UPD, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [MW_W-1:0]     clr_r, clr_nxt;
  logic [DATA_W-1:0]   base_r, base_nxt;
  logic [BS_W-1:0]     bsize_r, bsize_nxt;
  logic [WC_W-1:0]     wcount_r, wcount_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [DATA_W-1:0]   faddr_r, faddr_nxt;
  logic [WC_W-1:0]     ptr_r, ptr_nxt;
  logic [WC_W-1:0]     rd_word_r, rd_word_nxt;
  logic                rd_valid_r, rd_valid_nxt;
  logic [IX_W-1:0]     idx_r, idx_nxt;
  logic [OFF_W-1:0]    prod_r, prod_nxt;
  logic [WC_W+BS_W-1:0] span_r, span_nxt;
  logic [DATA_W:0]     off_r, off_nxt;
  logic [BS_W-1:0]     rem_r, rem_nxt;
  logic [IX_W-1:0]     lo_r, lo_nxt;
  logic [DIV_CW-1:0]   dcnt_r, dcnt_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [DATA_W-1:0]   res_addr_r, res_addr_nxt;
  logic [OUT_IX_W-1:0] res_index_r, res_index_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_addr_r, out_addr_nxt;
  logic [OUT_IX_W-1:0] out_index_r, out_index_nxt;
  logic [CNT_W-1:0]    out_used_r, out_used_nxt;

  logic                 mem_we, mem_re;
  logic [MW_W-1:0]      mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  logic [WC_W-1:0]      nw;
  logic [WORD_BITS-1:0] lowbit, fbit;
  logic [BIT_W-1:0]     bitpos;
  logic [BS_W:0]        trial, diff;
  logic [DATA_W:0]      sum;
  logic                 issue, cfg_wr;
  cfg_reg_t             cfg_sel;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (MW_W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign nw       = (wcount_r > WC_W'(NW_CAP)) ? WC_W'(NW_CAP) : wcount_r;
  assign in_stall = (state_r != S_IDLE);
  assign pready   = 1'b1;
  assign cfg_sel  = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_addr  = out_addr_r;
  assign out_block_index = out_index_r;
  assign out_used_count  = out_used_r;

  always_comb begin
    unique case (cfg_sel)
      REG_ARENA_BASE: prdata = base_r;
      REG_BLOCK_SIZE: prdata = DATA_W'(bsize_r);
      REG_WORD_COUNT: prdata = DATA_W'(wcount_r);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    lowbit = mem_rdata & (~mem_rdata + WORD_BITS'(1));
    bitpos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowbit[j]) begin
        bitpos = bitpos | BIT_W'(j);
      end
    end
  end

  assign fbit  = WORD_BITS'(1) << idx_r[BIT_W-1:0];
  assign trial = {rem_r, lo_r[IX_W-1]};
  assign diff  = trial - {1'b0, bsize_r};
  assign sum   = {1'b0, base_r} + (DATA_W+1)'(prod_r);
  assign issue = (ptr_r < nw);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    base_nxt       = base_r;
    bsize_nxt      = bsize_r;
    wcount_nxt     = wcount_r;
    used_nxt       = used_r;
    faddr_nxt      = faddr_r;
    ptr_nxt        = ptr_r;
    rd_word_nxt    = rd_word_r;
    rd_valid_nxt   = rd_valid_r;
    idx_nxt        = idx_r;
    prod_nxt       = prod_r;
    span_nxt       = span_r;
    off_nxt        = off_r;
    rem_nxt        = rem_r;
    lo_nxt         = lo_r;
    dcnt_nxt       = dcnt_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_index_nxt  = out_index_r;
    out_used_nxt   = out_used_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_r;
    mem_wdata      = '1;
    mem_re         = 1'b0;
    mem_raddr      = MW_W'(ptr_r);

    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_ARENA_BASE: base_nxt   = pwdata;
        REG_BLOCK_SIZE: bsize_nxt  = pwdata[BS_W-1:0];
        REG_WORD_COUNT: wcount_nxt = pwdata[WC_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_r == MW_W'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + MW_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          faddr_nxt     = in_free_addr;
          res_addr_nxt  = '0;
          res_index_nxt = '0;
          if (in_func == FUNC_ALLOC) begin
            if (nw == '0) begin
              res_status_nxt = ST_NONE_FREE;
              state_nxt      = S_FIN;
            end else begin
              ptr_nxt      = '0;
              rd_valid_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
          end else begin
            state_nxt = S_SPAN;
          end
        end
      end
      S_SCAN: begin
        rd_valid_nxt = issue;
        if (issue) begin
          mem_re      = 1'b1;
          mem_raddr   = MW_W'(ptr_r);
          ptr_nxt     = ptr_r + WC_W'(1);
          rd_word_nxt = ptr_r;
        end
        if (rd_valid_r) begin
          if (mem_rdata != '0) begin
            mem_we       = 1'b1;
            mem_waddr    = MW_W'(rd_word_r);
            mem_wdata    = mem_rdata & ~lowbit;
            idx_nxt      = {rd_word_r, bitpos};
            rd_valid_nxt = 1'b0;
            state_nxt    = S_MUL;
          end else if (!issue) begin
            res_status_nxt = ST_NONE_FREE;
            state_nxt      = S_FIN;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = OFF_W'(idx_r * bsize_r);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        res_status_nxt = ST_OK;
        res_addr_nxt   = sum[DATA_W-1:0] & AMASK;
        res_index_nxt  = idx_r[OUT_IX_W-1:0];
        used_nxt       = used_r + CNT_W'(1);
        state_nxt      = S_FIN;
      end
      S_SPAN: begin
        span_nxt  = (WC_W+BS_W)'(nw * bsize_r);
        off_nxt   = {1'b0, faddr_r} - {1'b0, base_r};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (off_r >= (DATA_W+1)'({span_r, BIT_W'(0)})) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_FIN;
        end else begin
          rem_nxt   = off_r[OFF_W-1:IX_W];
          lo_nxt    = off_r[IX_W-1:0];
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!diff[BS_W]) begin
          rem_nxt = diff[BS_W-1:0];
          lo_nxt  = {lo_r[IX_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[BS_W-1:0];
          lo_nxt  = {lo_r[IX_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DIV_CW'(1);
        if (dcnt_r == DIV_CW'(IX_W - 1)) begin
          state_nxt = S_IDX;
        end
      end
      S_IDX: begin
        idx_nxt = lo_r;
        if (rem_r != '0) begin
          res_status_nxt = ST_UNALIGNED;
          state_nxt      = S_FIN;
        end else if (int'(lo_r[IX_W-1:BIT_W]) >= MAP_WORDS) begin
          res_status_nxt = ST_NOT_ALLOC;
          state_nxt      = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = MW_W'(lo_r[IX_W-1:BIT_W]);
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if ((mem_rdata & fbit) != '0) begin
          res_status_nxt = ST_NOT_ALLOC;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = MW_W'(idx_r[IX_W-1:BIT_W]);
          mem_wdata      = mem_rdata | fbit;
          used_nxt       = (used_r == '0) ? used_r : used_r - CNT_W'(1);
          res_status_nxt = ST_OK;
          res_index_nxt  = idx_r[OUT_IX_W-1:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_index_nxt  = res_index_r;
          out_used_nxt   = used_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      base_r      <= BASE_RST;
      bsize_r     <= BS_RST;
      wcount_r    <= WC_RST;
      used_r      <= '0;
      ptr_r       <= '0;
      rd_valid_r  <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      base_r      <= base_nxt;
      bsize_r     <= bsize_nxt;
      wcount_r    <= wcount_nxt;
      used_r      <= used_nxt;
      ptr_r       <= ptr_nxt;
      rd_valid_r  <= rd_valid_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    faddr_r      <= faddr_nxt;
    rd_word_r    <= rd_word_nxt;
    idx_r        <= idx_nxt;
    prod_r       <= prod_nxt;
    span_r       <= span_nxt;
    off_r        <= off_nxt;
    rem_r        <= rem_nxt;
    lo_r         <= lo_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_index_r  <= out_index_nxt;
    out_used_r   <= out_used_nxt;
  end

  `BBA_ASSERT_NOW(a_clear_fill, (state_r == S_CLEAR), (mem_we && (mem_wdata == '1)))
  `BBA_ASSERT_NOW(a_rw_apart, (mem_we && mem_re), (mem_waddr != mem_raddr))
  `BBA_ASSERT_NOW(a_div_rem, (state_r == S_DIV), (rem_r < bsize_r))
  `BBA_ASSERT_NEXT(a_free_count, (state_r == S_UPD && mem_we),
                   ((used_r == $past(used_r) - CNT_W'(1)) || ($past(used_r) == '0)))

endmodule
